FILE: design/pydm_pkg.sv
package pydm_pkg;

    localparam int MAX_QUBITS  = 6;
    localparam int DIM_W       = MAX_QUBITS;
    localparam int STORE_DEPTH = ((1 << MAX_QUBITS) * ((1 << MAX_QUBITS) + 1)) / 2;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int PART_W      = 32;
    localparam int DATA_W      = 2 * PART_W;
    localparam int QB_W        = 3;

    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_READ    = 2'd1;
    localparam logic [1:0] OP_APPLY_Y = 2'd2;

    localparam logic ST_DONE  = 1'b0;
    localparam logic ST_ERROR = 1'b1;

    typedef struct packed {
        logic [1:0]               opcode;
        logic [DIM_W-1:0]         row;
        logic [DIM_W-1:0]         col;
        logic signed [PART_W-1:0] in_re;
        logic signed [PART_W-1:0] in_im;
        logic [QB_W-1:0]          target;
    } t_in_item;

    typedef struct packed {
        logic signed [PART_W-1:0] out_re;
        logic signed [PART_W-1:0] out_im;
        logic                     status;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_Y_SCAN,
        S_Y_RDB,
        S_Y_WRA,
        S_Y_WRB,
        S_DONE
    } t_state;

    // sweep control from the sequencer
    typedef struct packed {
        logic            start;
        logic            step;
        logic [QB_W-1:0] target;
        logic [QB_W-1:0] qubits;
    } t_sweep_ctl;

    // current sweep position and the pair it belongs to
    typedef struct packed {
        logic [ADDR_W-1:0] own_idx;
        logic [ADDR_W-1:0] part_idx;
        logic              do_pair;
        logic              neg_re;
        logic              neg_im;
        logic              last;
    } t_sweep_pos;

    function automatic logic signed [PART_W-1:0] neg_sat(input logic signed [PART_W-1:0] x);
        logic signed [PART_W-1:0] min_val;
        min_val = {1'b1, {(PART_W-1){1'b0}}};
        if (x == min_val) begin
            return {1'b0, {(PART_W-1){1'b1}}};
        end
        return -x;
    endfunction

    // lower-triangle entry index, row-major, r >= c
    function automatic logic [ADDR_W-1:0] tri_idx(input logic [DIM_W-1:0] r,
                                                   input logic [DIM_W-1:0] c);
        logic [2*DIM_W:0] prod;
        prod = {{(DIM_W+1){1'b0}}, r} * ({{(DIM_W+1){1'b0}}, r} + {{(2*DIM_W){1'b0}}, 1'b1});
        return prod[ADDR_W:1] + {{(ADDR_W-DIM_W){1'b0}}, c};
    endfunction

    function automatic logic [QB_W-1:0] eff_qubits(input logic [QB_W-1:0] q);
        if (q < QB_W'(1)) begin
            return QB_W'(1);
        end
        if (q > QB_W'(MAX_QUBITS)) begin
            return QB_W'(MAX_QUBITS);
        end
        return q;
    endfunction

    function automatic logic [DATA_W-1:0] y_xform(input logic [DATA_W-1:0] v,
                                                   input logic nre, input logic nim);
        logic signed [PART_W-1:0] re;
        logic signed [PART_W-1:0] im;
        re = v[DATA_W-1:PART_W];
        im = v[PART_W-1:0];
        if (nre) begin
            re = neg_sat(re);
        end
        if (nim) begin
            im = neg_sat(im);
        end
        return {re, im};
    endfunction

endpackage

FILE: design/pydm_ram.sv
module pydm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2080
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/pydm_sweep.sv
module pydm_sweep (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  pydm_pkg::t_sweep_ctl   i_ctl,
    output pydm_pkg::t_sweep_pos   o_pos
);

    logic [pydm_pkg::DIM_W-1:0] r_row, n_row;
    logic [pydm_pkg::DIM_W-1:0] r_col, n_col;
    logic [pydm_pkg::DIM_W-1:0] r_last_row, n_last_row;
    logic [pydm_pkg::QB_W-1:0]  r_tgt, n_tgt;

    logic [pydm_pkg::DIM_W-1:0] mask;
    logic [pydm_pkg::DIM_W-1:0] row_x, col_x, prow, pcol;
    logic                       flip;
    logic [pydm_pkg::DIM_W-1:0] diff;

    always_comb begin
        mask  = pydm_pkg::DIM_W'(1) << r_tgt;
        row_x = r_row ^ mask;
        col_x = r_col ^ mask;
        flip  = row_x < col_x;
        prow  = flip ? col_x : row_x;
        pcol  = flip ? row_x : col_x;
        diff  = (r_row ^ r_col) & mask;

        o_pos.own_idx  = pydm_pkg::tri_idx(r_row, r_col);
        o_pos.part_idx = pydm_pkg::tri_idx(prow, pcol);
        // a pair is handled from its lower-indexed member; a self-mirrored entry too
        o_pos.do_pair  = o_pos.own_idx <= o_pos.part_idx;
        o_pos.neg_re   = diff != '0;
        o_pos.neg_im   = (diff != '0) ^ flip;
        o_pos.last     = (r_row == r_last_row) && (r_col == r_row);
    end

    always_comb begin
        n_row      = r_row;
        n_col      = r_col;
        n_last_row = r_last_row;
        n_tgt      = r_tgt;
        if (i_ctl.start) begin
            n_row      = '0;
            n_col      = '0;
            n_tgt      = i_ctl.target;
            n_last_row = pydm_pkg::DIM_W'((pydm_pkg::DIM_W+1)'(1) << i_ctl.qubits) - 1'b1;
        end else if (i_ctl.step) begin
            if (r_col == r_row) begin
                n_row = r_row + 1'b1;
                n_col = '0;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row      <= '0;
            r_col      <= '0;
            r_last_row <= '0;
            r_tgt      <= '0;
        end else begin
            r_row      <= n_row;
            r_col      <= n_col;
            r_last_row <= n_last_row;
            r_tgt      <= n_tgt;
        end
    end

endmodule

FILE: design/pauli_y_density_matrix_engine_top.sv
// A write or a rejected item reaches the output register in the cycle after acceptance;
//   a read goes through the registered memory read and S_READ, which waits for a free output.
// Apply-Y sweeps the N = D(D+1)/2 stored entries: a scan state (S_Y_SCAN) for each entry, then
//   S_Y_RDB, S_Y_WRA and S_Y_WRB for each swap pair or self-mirrored entry; the result is
//   loaded from S_DONE once the output is free.
// Throughput: one item at a time; the single-port-write store sets the sweep length.
// Reset: synchronous active-low; clears control and sets num_qubits to 1. Store is not cleared.
module pauli_y_density_matrix_engine_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  pydm_pkg::t_in_item            i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output pydm_pkg::t_out_item           o_out_item,
    input  logic                          i_cfg_we,
    input  logic [pydm_pkg::QB_W-1:0]     i_cfg_wdata
);

    pydm_pkg::t_state r_state, n_state;

    logic [pydm_pkg::QB_W-1:0]   r_num_qubits;
    logic                        r_out_valid, n_out_valid;
    pydm_pkg::t_out_item         r_out_item, n_out_item;
    logic [pydm_pkg::ADDR_W-1:0] r_rd_addr, n_rd_addr;
    logic                        r_conj, n_conj;
    logic [pydm_pkg::DATA_W-1:0] r_own, n_own;

    // memory port controls
    logic                        ram_we;
    logic [pydm_pkg::ADDR_W-1:0] ram_waddr;
    logic [pydm_pkg::DATA_W-1:0] ram_wdata;
    logic [pydm_pkg::ADDR_W-1:0] ram_raddr;
    logic [pydm_pkg::DATA_W-1:0] ram_rdata;

    pydm_pkg::t_sweep_ctl sw_ctl;
    pydm_pkg::t_sweep_pos sw_pos;

    // decode of the incoming item
    logic [pydm_pkg::QB_W-1:0]  q_eff;
    logic                       in_acc;
    logic                       out_free;
    logic                       idx_bad;
    logic                       tgt_bad;
    logic                       in_upper;
    logic [pydm_pkg::DIM_W-1:0] lo_row, lo_col;
    logic [pydm_pkg::ADDR_W-1:0] in_idx;
    logic signed [pydm_pkg::PART_W-1:0] rd_re, rd_im;

    assign q_eff    = pydm_pkg::eff_qubits(r_num_qubits);
    assign out_free = !r_out_valid || !i_out_stall;
    assign in_acc   = i_in_valid && !o_in_stall;
    assign idx_bad  = ((i_in_item.row >> q_eff) != '0) || ((i_in_item.col >> q_eff) != '0);
    assign tgt_bad  = i_in_item.target >= q_eff;
    assign in_upper = i_in_item.row < i_in_item.col;
    assign lo_row   = in_upper ? i_in_item.col : i_in_item.row;
    assign lo_col   = in_upper ? i_in_item.row : i_in_item.col;
    assign in_idx   = pydm_pkg::tri_idx(lo_row, lo_col);
    assign rd_re    = ram_rdata[pydm_pkg::DATA_W-1:pydm_pkg::PART_W];
    assign rd_im    = ram_rdata[pydm_pkg::PART_W-1:0];

    pydm_ram #(
        .WIDTH(pydm_pkg::DATA_W),
        .DEPTH(pydm_pkg::STORE_DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    pydm_sweep u_sweep (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (sw_ctl),
        .o_pos  (sw_pos)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pydm_pkg::S_IDLE: begin
                if (in_acc) begin
                    case (i_in_item.opcode)
                        pydm_pkg::OP_READ: begin
                            if (!idx_bad) begin
                                n_state = pydm_pkg::S_READ;
                            end
                        end
                        pydm_pkg::OP_APPLY_Y: begin
                            if (!tgt_bad) begin
                                n_state = pydm_pkg::S_Y_SCAN;
                            end
                        end
                        default: n_state = pydm_pkg::S_IDLE;
                    endcase
                end
            end
            pydm_pkg::S_READ: begin
                if (out_free) begin
                    n_state = pydm_pkg::S_IDLE;
                end
            end
            pydm_pkg::S_Y_SCAN: begin
                if (sw_pos.do_pair) begin
                    n_state = pydm_pkg::S_Y_RDB;
                end else if (sw_pos.last) begin
                    n_state = pydm_pkg::S_DONE;
                end
            end
            pydm_pkg::S_Y_RDB: n_state = pydm_pkg::S_Y_WRA;
            pydm_pkg::S_Y_WRA: n_state = pydm_pkg::S_Y_WRB;
            pydm_pkg::S_Y_WRB: begin
                n_state = sw_pos.last ? pydm_pkg::S_DONE : pydm_pkg::S_Y_SCAN;
            end
            pydm_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = pydm_pkg::S_IDLE;
                end
            end
            default: n_state = pydm_pkg::S_IDLE;
        endcase
    end

    // outputs of the sequencer: memory ports, sweep control, result loading
    always_comb begin
        o_in_stall    = !((r_state == pydm_pkg::S_IDLE) && out_free);
        ram_we        = 1'b0;
        ram_waddr     = sw_pos.own_idx;
        ram_wdata     = pydm_pkg::y_xform(ram_rdata, sw_pos.neg_re, sw_pos.neg_im);
        ram_raddr     = r_rd_addr;
        sw_ctl.start  = 1'b0;
        sw_ctl.step   = 1'b0;
        sw_ctl.target = i_in_item.target;
        sw_ctl.qubits = q_eff;
        n_rd_addr     = r_rd_addr;
        n_conj        = r_conj;
        n_own         = r_own;
        // drop the held result once taken
        n_out_valid   = r_out_valid && i_out_stall;
        n_out_item    = r_out_item;

        case (r_state)
            pydm_pkg::S_IDLE: begin
                ram_raddr = in_idx;
                if (in_acc) begin
                    n_out_item = '{out_re: '0, out_im: '0, status: pydm_pkg::ST_DONE};
                    case (i_in_item.opcode)
                        pydm_pkg::OP_WRITE: begin
                            n_out_valid = 1'b1;
                            if (idx_bad) begin
                                n_out_item.status = pydm_pkg::ST_ERROR;
                            end else begin
                                // an upper write lands on the mirror as its conjugate
                                ram_we    = 1'b1;
                                ram_waddr = in_idx;
                                ram_wdata = {i_in_item.in_re,
                                             in_upper ? pydm_pkg::neg_sat(i_in_item.in_im)
                                                      : i_in_item.in_im};
                            end
                        end
                        pydm_pkg::OP_READ: begin
                            if (idx_bad) begin
                                n_out_valid       = 1'b1;
                                n_out_item.status = pydm_pkg::ST_ERROR;
                            end else begin
                                n_rd_addr = in_idx;
                                n_conj    = in_upper;
                            end
                        end
                        pydm_pkg::OP_APPLY_Y: begin
                            if (tgt_bad) begin
                                n_out_valid       = 1'b1;
                                n_out_item.status = pydm_pkg::ST_ERROR;
                            end else begin
                                sw_ctl.start = 1'b1;
                            end
                        end
                        default: begin
                            n_out_valid       = 1'b1;
                            n_out_item.status = pydm_pkg::ST_ERROR;
                        end
                    endcase
                end
            end
            pydm_pkg::S_READ: begin
                // hold the read address so the data stays while the output is blocked
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_item  = '{out_re: rd_re,
                                    out_im: r_conj ? pydm_pkg::neg_sat(rd_im) : rd_im,
                                    status: pydm_pkg::ST_DONE};
                end
            end
            pydm_pkg::S_Y_SCAN: begin
                ram_raddr = sw_pos.own_idx;
                if (!sw_pos.do_pair && !sw_pos.last) begin
                    sw_ctl.step = 1'b1;
                end
            end
            pydm_pkg::S_Y_RDB: begin
                ram_raddr = sw_pos.part_idx;
                n_own     = ram_rdata;
            end
            pydm_pkg::S_Y_WRA: begin
                // own entry takes the transformed partner
                ram_we    = 1'b1;
                ram_waddr = sw_pos.own_idx;
            end
            pydm_pkg::S_Y_WRB: begin
                ram_we    = 1'b1;
                ram_waddr = sw_pos.part_idx;
                ram_wdata = pydm_pkg::y_xform(r_own, sw_pos.neg_re, sw_pos.neg_im);
                if (!sw_pos.last) begin
                    sw_ctl.step = 1'b1;
                end
            end
            pydm_pkg::S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_item  = '{out_re: '0, out_im: '0, status: pydm_pkg::ST_DONE};
                end
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= pydm_pkg::S_IDLE;
            r_out_valid  <= 1'b0;
            r_num_qubits <= pydm_pkg::QB_W'(1);
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_num_qubits <= i_cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_out_item <= n_out_item;
        r_rd_addr  <= n_rd_addr;
        r_conj     <= n_conj;
        r_own      <= n_own;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // the store is only written by an accepted write or in the sweep write cycles
    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (in_acc && (i_in_item.opcode == pydm_pkg::OP_WRITE))
                   || (r_state == pydm_pkg::S_Y_WRA) || (r_state == pydm_pkg::S_Y_WRB))
        else $error("store written outside a write cycle");

    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> (r_state == pydm_pkg::S_IDLE))
        else $error("item taken while busy");

    a_read_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in_item.opcode == pydm_pkg::OP_READ) && !idx_bad)
        |=> (r_state == pydm_pkg::S_READ))
        else $error("valid read did not enter read state");

    a_sweep_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pydm_pkg::S_DONE) && out_free |=> o_out_valid)
        else $error("sweep finished without a result");

endmodule
